### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// expects signals clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition that holds every clock outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

### hw/rtl/rfd_pkg.sv
// constants and types for the request frame deframer
// no dependencies
`timescale 1ns / 1ps

package rfd_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;

  localparam logic [7:0]  START_BYTE_RST   = 8'h5A;
  localparam logic [15:0] TIMEOUT_RST      = 16'd120;
  localparam logic        STRICT_RST       = 1'b0;
  localparam logic [7:0]  CHK_XOR          = 8'hFF;
  localparam logic [7:0]  LEN_OVERHEAD     = 8'd2;
  localparam logic [6:0]  PLEN_CAP         = 7'd127;
  localparam logic [15:0] IDLE_SAT         = 16'hFFFF;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRICT     = 2'd2;

  localparam logic IN_KIND_BYTE = 1'b0;
  localparam logic IN_KIND_TICK = 1'b1;

  localparam logic OUT_KIND_PAYLOAD = 1'b0;
  localparam logic OUT_KIND_END     = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_BADLEN  = 2'd2,
    ST_BADSUM  = 2'd3
  } status_t;

  // result tdata, first field in the high bits
  typedef struct packed {
    logic       checksum_ok;
    status_t    status;
    logic [6:0] decl_len;
    logic [7:0] command;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
  } out_data_t;

  typedef struct packed {
    logic      kind;
    logic      last;
    out_data_t data;
  } out_item_t;

endpackage

### hw/rtl/request_frame_deframer_core.sv
// request frame deframer: hunts start byte, streams payload, checks sum
// depends on rfd_pkg and assert_macros.svh
`timescale 1ns / 1ps
//
// channel | dir | handshake          | contents
// in_     | in  | in_tvalid/tready   | tdata rx_byte, tuser cmd (byte or tick)
// out_    | out | out_tvalid/tready  | tdata frame fields, tuser kind, tlast
// cfg_    | in  | cfg_valid/ready    | cfg_index register, cfg_data value
//
// one input item per cycle while in_tready is high, result registered on the transfer
// two-entry output buffer (result register plus skid) decouples the sides
// in_tready drops only while both output entries hold results
// cfg_ready is always high, writes take effect on the next cycle
// synchronous active-low reset restores registers (not the output data) and hunting

`include "assert_macros.svh"

module request_frame_deframer_core #(
  parameter int MAX_PAYLOAD = rfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] rx_byte
  input  logic                           in_tuser,   // [0] cmd
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] payload_byte, [13:8] byte_index, [21:14] command,
  // [28:22] decl_len, [30:29] status, [31] checksum_ok
  output logic [31:0]                    out_tdata,
  output logic                           out_tuser,  // [0] item_kind
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic [7:0] MaxPl = 8'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_CMD,
    PH_DATA,
    PH_CHECK
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [7:0]         start_byte_r, start_byte_nxt;
  logic [15:0]        timeout_r, timeout_nxt;
  logic               strict_r, strict_nxt;
  logic [7:0]         len_r, len_nxt;
  logic [7:0]         fcmd_r, fcmd_nxt;
  logic [7:0]         seen_r, seen_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic [15:0]        idle_r, idle_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  rfd_pkg::out_item_t out_r, out_nxt;
  rfd_pkg::out_item_t skid_r, skid_nxt;

  logic               in_xfer, out_xfer;
  logic               res_valid;
  logic               res_end;
  logic               res_chk_ok;
  rfd_pkg::status_t   res_status;
  rfd_pkg::out_item_t res;
  logic [7:0]         dlen;
  logic [7:0]         len_m2;
  logic [15:0]        idle_inc;
  logic [7:0]         sum_add;
  logic [7:0]         seen_inc;

  assign in_tready  = !skid_valid_r;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_xfer   = out_valid_r && out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

  // declared payload length seen from the current phase
  assign len_m2 = len_r - rfd_pkg::LEN_OVERHEAD;
  always_comb begin
    if (phase_r == PH_HUNT || phase_r == PH_LEN || len_r < rfd_pkg::LEN_OVERHEAD) begin
      dlen = 8'd0;
    end else if (len_m2 > MaxPl) begin
      dlen = MaxPl;
    end else begin
      dlen = len_m2;
    end
  end

  assign idle_inc = (idle_r == rfd_pkg::IDLE_SAT) ? idle_r : idle_r + 16'd1;
  assign sum_add  = sum_r + in_tdata;
  assign seen_inc = seen_r + 8'd1;

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    fcmd_nxt   = fcmd_r;
    seen_nxt   = seen_r;
    sum_nxt    = sum_r;
    idle_nxt   = idle_r;
    res_valid  = 1'b0;
    res_end    = 1'b0;
    res_status = rfd_pkg::ST_OK;
    res_chk_ok = 1'b0;
    if (in_xfer) begin
      if (in_tuser == rfd_pkg::IN_KIND_TICK) begin
        if (phase_r != PH_HUNT) begin
          idle_nxt = idle_inc;
          if (idle_inc >= timeout_r) begin
            res_valid  = 1'b1;
            res_end    = 1'b1;
            res_status = rfd_pkg::ST_TIMEOUT;
          end
        end
      end else begin
        idle_nxt = 16'd0;
        case (phase_r)
          PH_HUNT: begin
            if (in_tdata == start_byte_r) begin
              phase_nxt = PH_LEN;
              len_nxt   = 8'd0;
              fcmd_nxt  = 8'd0;
              seen_nxt  = 8'd0;
              sum_nxt   = in_tdata;
            end
          end
          PH_LEN: begin
            len_nxt   = in_tdata;
            sum_nxt   = sum_add;
            phase_nxt = PH_CMD;
          end
          PH_CMD: begin
            fcmd_nxt = in_tdata;
            sum_nxt  = sum_add;
            seen_nxt = 8'd0;
            if (len_r < rfd_pkg::LEN_OVERHEAD || len_m2 > MaxPl) begin
              res_valid  = 1'b1;
              res_end    = 1'b1;
              res_status = rfd_pkg::ST_BADLEN;
            end else if (len_r == rfd_pkg::LEN_OVERHEAD) begin
              phase_nxt = PH_CHECK;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            sum_nxt   = sum_add;
            res_valid = 1'b1;
            seen_nxt  = seen_inc;
            if (seen_inc >= dlen) begin
              phase_nxt = PH_CHECK;
            end
          end
          PH_CHECK: begin
            res_valid = 1'b1;
            res_end   = 1'b1;
            if ((sum_r ^ rfd_pkg::CHK_XOR) == in_tdata) begin
              res_chk_ok = 1'b1;
            end else if (strict_r) begin
              res_status = rfd_pkg::ST_BADSUM;
            end
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
      if (res_end) begin
        phase_nxt = PH_HUNT;
        idle_nxt  = 16'd0;
      end
    end
  end

  // result item built from the current item and frame state
  always_comb begin
    res.kind              = res_end ? rfd_pkg::OUT_KIND_END : rfd_pkg::OUT_KIND_PAYLOAD;
    res.last              = res_end;
    res.data.payload_byte = res_end ? 8'd0 : in_tdata;
    res.data.byte_index   = res_end ? 6'd0 : seen_r[5:0];
    res.data.command      = fcmd_nxt;
    res.data.decl_len     = (dlen > 8'(rfd_pkg::PLEN_CAP)) ? rfd_pkg::PLEN_CAP : dlen[6:0];
    res.data.status       = res_status;
    res.data.checksum_ok  = res_chk_ok;
  end

  // two-entry output buffer
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_xfer && skid_valid_r) begin
      out_nxt        = skid_r;
      skid_valid_nxt = 1'b0;
    end else if (out_xfer || !out_valid_r) begin
      out_valid_nxt = res_valid;
      out_nxt       = res;
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_comb begin
    start_byte_nxt = start_byte_r;
    timeout_nxt    = timeout_r;
    strict_nxt     = strict_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rfd_pkg::CFG_START_BYTE: start_byte_nxt = cfg_data[7:0];
        rfd_pkg::CFG_TIMEOUT:    timeout_nxt    = cfg_data;
        rfd_pkg::CFG_STRICT:     strict_nxt     = cfg_data[0];
        default:                 start_byte_nxt = start_byte_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      start_byte_r <= rfd_pkg::START_BYTE_RST;
      timeout_r    <= rfd_pkg::TIMEOUT_RST;
      strict_r     <= rfd_pkg::STRICT_RST;
      len_r        <= 8'd0;
      fcmd_r       <= 8'd0;
      seen_r       <= 8'd0;
      sum_r        <= 8'd0;
      idle_r       <= 16'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      start_byte_r <= start_byte_nxt;
      timeout_r    <= timeout_nxt;
      strict_r     <= strict_nxt;
      len_r        <= len_nxt;
      fcmd_r       <= fcmd_nxt;
      seen_r       <= seen_nxt;
      sum_r        <= sum_nxt;
      idle_r       <= idle_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  `ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r,
              "skid holds a result with empty output")
  `ASSERT_IMP(a_hunt_idle_clear, phase_r == PH_HUNT, idle_r == 16'd0,
              "idle count kept while hunting")
  `ASSERT_IMP(a_data_index_range, phase_r == PH_DATA, seen_r < dlen,
              "payload index past declared length")
  `ASSERT_IMP(a_payload_fields, out_valid_r && out_r.kind == rfd_pkg::OUT_KIND_PAYLOAD,
              out_r.data.status == rfd_pkg::ST_OK && !out_r.data.checksum_ok && !out_r.last,
              "payload item with end fields")

endmodule

### tb/tb_request_frame_deframer_core.sv
// testbench for request_frame_deframer_core: directed frames, then random frames and noise
// under several register settings, results checked against an in-bench frame predictor
// depends on rfd_pkg and the core rtl
`timescale 1ns / 1ps

module tb_request_frame_deframer_core;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASE_ITEMS = 330;
  localparam logic [rfd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef enum logic [2:0] {
    P_HUNT, P_LEN, P_CMD, P_DATA, P_SUM
  } rx_phase_t;

  typedef struct {
    logic               kind;
    logic [7:0]         rx;
    bit                 typed;
    rfd_pkg::out_item_t want;
  } script_row_t;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [31:0]                    out_tdata;
  logic                           out_tuser;
  logic                           out_tlast;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [rfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rfd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // frame predictor state and register copies
  rx_phase_t   fr_phase = P_HUNT;
  logic [7:0]  fr_len = '0;
  logic [7:0]  fr_cmd = '0;
  logic [6:0]  fr_seen = '0;
  logic [7:0]  fr_sum = '0;
  logic [15:0] fr_idle = '0;
  logic [7:0]  start_byte_q = rfd_pkg::START_BYTE_RST;
  logic [15:0] timeout_q = rfd_pkg::TIMEOUT_RST;
  logic        strict_q = rfd_pkg::STRICT_RST;

  rfd_pkg::out_item_t pending_results[$];
  script_row_t        script[24];
  int unsigned        driven_items = 0;
  int unsigned        fail_count = 0;
  int unsigned        cycle_count = 0;
  int unsigned        snd_idle_pct = 0;
  int unsigned        rcv_idle_pct = 0;

  request_frame_deframer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  function automatic rfd_pkg::out_item_t make_result(logic kind, logic [7:0] pb,
                                                     logic [5:0] idx, logic [7:0] cmd,
                                                     logic [6:0] plen,
                                                     rfd_pkg::status_t st, logic ok);
    rfd_pkg::out_item_t r;
    r.kind              = kind;
    r.last              = kind;
    r.data.payload_byte = pb;
    r.data.byte_index   = idx;
    r.data.command      = cmd;
    r.data.decl_len     = plen;
    r.data.status       = st;
    r.data.checksum_ok  = ok;
    return r;
  endfunction

  function automatic logic [6:0] declared_payload();
    int n;
    if (fr_phase == P_HUNT || fr_phase == P_LEN || fr_len < rfd_pkg::LEN_OVERHEAD) return '0;
    n = int'(fr_len) - int'(rfd_pkg::LEN_OVERHEAD);
    if (n > rfd_pkg::MAX_PAYLOAD_DEF) n = rfd_pkg::MAX_PAYLOAD_DEF;
    return n[6:0];
  endfunction

  function automatic rfd_pkg::out_item_t close_frame(rfd_pkg::status_t st, logic ok);
    rfd_pkg::out_item_t r;
    r = make_result(rfd_pkg::OUT_KIND_END, 8'h00, 6'd0, fr_cmd, declared_payload(), st, ok);
    fr_phase = P_HUNT;
    fr_idle  = '0;
    return r;
  endfunction

  task automatic deframe_step(input logic kind, input logic [7:0] b,
                              output bit produced, output rfd_pkg::out_item_t res);
    produced = 1'b0;
    res      = '0;
    if (kind == rfd_pkg::IN_KIND_TICK) begin
      if (fr_phase != P_HUNT) begin
        if (fr_idle != rfd_pkg::IDLE_SAT) fr_idle = fr_idle + 16'd1;
        if (fr_idle >= timeout_q) begin
          res      = close_frame(rfd_pkg::ST_TIMEOUT, 1'b0);
          produced = 1'b1;
        end
      end
    end else begin
      fr_idle = '0;
      case (fr_phase)
        P_HUNT: begin
          if (b == start_byte_q) begin
            fr_phase = P_LEN;
            fr_len   = '0;
            fr_cmd   = '0;
            fr_seen  = '0;
            fr_sum   = b;
          end
        end
        P_LEN: begin
          fr_len   = b;
          fr_sum   = fr_sum + b;
          fr_phase = P_CMD;
        end
        P_CMD: begin
          fr_cmd = b;
          fr_sum = fr_sum + b;
          if (fr_len < rfd_pkg::LEN_OVERHEAD ||
              int'(fr_len) - int'(rfd_pkg::LEN_OVERHEAD) > rfd_pkg::MAX_PAYLOAD_DEF) begin
            res      = close_frame(rfd_pkg::ST_BADLEN, 1'b0);
            produced = 1'b1;
          end else begin
            fr_seen  = '0;
            fr_phase = (fr_len == rfd_pkg::LEN_OVERHEAD) ? P_SUM : P_DATA;
          end
        end
        P_DATA: begin
          fr_sum   = fr_sum + b;
          res      = make_result(rfd_pkg::OUT_KIND_PAYLOAD, b, fr_seen[5:0], fr_cmd,
                                 declared_payload(), rfd_pkg::ST_OK, 1'b0);
          produced = 1'b1;
          fr_seen  = fr_seen + 7'd1;
          if (fr_seen >= declared_payload()) fr_phase = P_SUM;
        end
        default: begin
          if ((fr_sum ^ rfd_pkg::CHK_XOR) == b) res = close_frame(rfd_pkg::ST_OK, 1'b1);
          else res = close_frame(strict_q ? rfd_pkg::ST_BADSUM : rfd_pkg::ST_OK, 1'b0);
          produced = 1'b1;
        end
      endcase
    end
  endtask

  task automatic send_item(input logic kind, input logic [7:0] b,
                           input bit typed = 1'b0,
                           input rfd_pkg::out_item_t typed_res = '0);
    bit                 produced;
    rfd_pkg::out_item_t res;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // bytes and ticks that hunting merely skips are not counted
    if (!(fr_phase == P_HUNT && (kind == rfd_pkg::IN_KIND_TICK || b != start_byte_q)))
      driven_items++;
    deframe_step(kind, b, produced, res);
    if (typed) pending_results.push_back(typed_res);
    else if (produced) pending_results.push_back(res);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(rfd_pkg::IN_KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_request_frame();
    logic [7:0]  frame_bytes[$];
    logic [7:0]  len;
    logic [7:0]  sum;
    int unsigned r;
    int unsigned cut;
    int unsigned gap_max;
    r = $urandom_range(0, 99);
    if (r < 4) len = 8'($urandom_range(0, 1));
    else if (r < 8) len = 8'($urandom_range(67, 255));
    else if (r < 11) len = 8'(rfd_pkg::MAX_PAYLOAD_DEF + 2);
    else if (r < 15) len = rfd_pkg::LEN_OVERHEAD;
    else len = 8'($urandom_range(3, 12));
    frame_bytes.push_back(start_byte_q);
    frame_bytes.push_back(len);
    frame_bytes.push_back(8'($urandom_range(0, 255)));
    if (len >= rfd_pkg::LEN_OVERHEAD && int'(len) - 2 <= rfd_pkg::MAX_PAYLOAD_DEF) begin
      repeat (int'(len) - 2) frame_bytes.push_back(8'($urandom_range(0, 255)));
      sum = '0;
      foreach (frame_bytes[i]) sum = sum + frame_bytes[i];
      if ($urandom_range(0, 99) < 70) frame_bytes.push_back(sum ^ rfd_pkg::CHK_XOR);
      else frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    cut = 0;
    if (timeout_q <= 200 && $urandom_range(0, 99) < 10)
      cut = $urandom_range(1, frame_bytes.size() - 1);
    gap_max = (timeout_q > 4) ? 4 : ((timeout_q > 0) ? timeout_q - 1 : 0);
    foreach (frame_bytes[i]) begin
      if (cut != 0 && i == cut) begin
        send_ticks((timeout_q == 0) ? 1 : timeout_q);
        return;
      end
      if (i > 0 && gap_max > 0 && $urandom_range(0, 99) < 15)
        send_ticks($urandom_range(1, gap_max));
      send_item(rfd_pkg::IN_KIND_BYTE, frame_bytes[i]);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rfd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rfd_pkg::CFG_START_BYTE: start_byte_q = val[7:0];
      rfd_pkg::CFG_TIMEOUT:    timeout_q    = val;
      rfd_pkg::CFG_STRICT:     strict_q     = val[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [7:0] sb, input logic [15:0] tmo,
                               input logic strict, input bit poke_unused);
    write_reg(rfd_pkg::CFG_START_BYTE, {8'($urandom_range(0, 255)), sb});
    write_reg(rfd_pkg::CFG_TIMEOUT, tmo);
    write_reg(rfd_pkg::CFG_STRICT, {15'($urandom_range(0, 32767)), strict});
    if (poke_unused) write_reg(CFG_UNUSED_IDX, 16'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    rfd_pkg::out_item_t want;
    rfd_pkg::out_item_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.last = out_tlast;
      got.data = out_tdata;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("item_kind", want.kind, got.kind);
        check_field("last", want.last, got.last);
        check_field("payload_byte", want.data.payload_byte, got.data.payload_byte);
        check_field("byte_index", want.data.byte_index, got.data.byte_index);
        check_field("command", want.data.command, got.data.command);
        check_field("decl_len", want.data.decl_len, got.data.decl_len);
        check_field("status", int'(want.data.status), int'(got.data.status));
        check_field("checksum_ok", want.data.checksum_ok, got.data.checksum_ok);
      end
    end
    out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  initial begin
    int          ph;
    int unsigned phase_goal;
    script = '{
      '{rfd_pkg::IN_KIND_TICK, 8'h00, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'h00, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'h5A, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'h00, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'hFF, 1'b1,
        make_result(rfd_pkg::OUT_KIND_END, 8'h00, 6'd0, 8'hFF, 7'd0,
                    rfd_pkg::ST_BADLEN, 1'b0)},
      '{rfd_pkg::IN_KIND_BYTE, 8'h5A, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'h01, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'h3C, 1'b1,
        make_result(rfd_pkg::OUT_KIND_END, 8'h00, 6'd0, 8'h3C, 7'd0,
                    rfd_pkg::ST_BADLEN, 1'b0)},
      '{rfd_pkg::IN_KIND_BYTE, 8'h5A, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'hFF, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'h00, 1'b1,
        make_result(rfd_pkg::OUT_KIND_END, 8'h00, 6'd0, 8'h00, 7'd64,
                    rfd_pkg::ST_BADLEN, 1'b0)},
      '{rfd_pkg::IN_KIND_BYTE, 8'h5A, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'h02, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'hA5, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'hFE, 1'b1,
        make_result(rfd_pkg::OUT_KIND_END, 8'h00, 6'd0, 8'hA5, 7'd0,
                    rfd_pkg::ST_OK, 1'b1)},
      '{rfd_pkg::IN_KIND_BYTE, 8'h5A, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'h03, 1'b0, '0},
      '{rfd_pkg::IN_KIND_TICK, 8'hFF, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'h81, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'h5A, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'h00, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'h5A, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'h43, 1'b0, '0},
      '{rfd_pkg::IN_KIND_BYTE, 8'h7F, 1'b1,
        make_result(rfd_pkg::OUT_KIND_END, 8'h00, 6'd0, 8'h7F, 7'd64,
                    rfd_pkg::ST_BADLEN, 1'b0)}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < 6; ph++) begin
      snd_idle_pct = (ph < 2) ? 14 : ((ph < 4) ? 47 : 0);
      rcv_idle_pct = (ph < 2) ? 47 : ((ph < 4) ? 14 : 0);
      if (ph == 0) begin
        foreach (script[i]) send_item(script[i].kind, script[i].rx, script[i].typed,
                                      script[i].want);
      end else begin
        drain_results();
        case (ph)
          1: load_settings(8'h00, 16'd1, 1'b1, 1'b0);
          2: load_settings(8'hFF, 16'hFFFF, 1'b0, 1'b0);
          3: load_settings(8'($urandom_range(0, 255)), 16'($urandom_range(2, 40)), 1'b1, 1'b1);
          4: load_settings(8'($urandom_range(0, 255)), 16'd0, 1'b0, 1'b0);
          default: load_settings(8'h5A, 16'($urandom_range(41, 150)), 1'b1, 1'b1);
        endcase
      end
      phase_goal = driven_items + PHASE_ITEMS;
      while (driven_items < phase_goal) begin
        if ($urandom_range(0, 99) < 80) begin
          send_request_frame();
        end else begin
          // noise between frames
          repeat ($urandom_range(1, 4))
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
